// ===== sv/edge_tapered_moving_average_unit_macros.svh =====
// Assertion macros for the edge tapered moving average unit
`ifndef EDGE_TAPERED_MOVING_AVERAGE_UNIT_MACROS_SVH
`define EDGE_TAPERED_MOVING_AVERAGE_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define ETMA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define ETMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/etma_pkg.sv =====
// Shared constants for the edge tapered moving average unit
package etma_pkg;

    localparam int WINDOW_DEF      = 19;
    localparam int SAMPLE_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int                    MEAN_BITS = 28;
    localparam logic [MEAN_BITS-1:0]  MEAN_MAX  = '1;

endpackage

// ===== sv/etma_ifs.sv =====
// Sample and mean stream interfaces of the edge tapered moving average unit
interface etma_sample_if #(
    parameter int SAMPLE_BITS = etma_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface etma_mean_if;
    import etma_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MEAN_BITS-1:0] mean_value;
    logic                 run_end;
    logic                 too_short;

    modport source (output valid, output mean_value, output run_end, output too_short,
                    input ready);
    modport sink   (input valid, input mean_value, input run_end, input too_short,
                    output ready);
endinterface

// ===== sv/edge_tapered_moving_average_unit.sv =====
// Edge tapered moving average: running window sum, reciprocal divide, result stream
//
//  channel   dir  payload                              transfer when
//  samples   in   sample, last_sample                  valid && ready
//  means     out  mean_value, run_end, too_short       valid && ready
//
//  One sample is taken per cycle while ready is high; any mean it yields is registered in
//  the request, multiply and output stages. A last sample holds ready low while its tail
//  means issue, one per cycle when req_adv, or while a short run's too_short mean issues.
//  Each stage has its own valid bit, so bubbles close up behind a stalled output.
//  rst_n clears all control state asynchronously; sample history and data carry no reset.
`include "edge_tapered_moving_average_unit_macros.svh"

module edge_tapered_moving_average_unit #(
    parameter int WINDOW      = etma_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = etma_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = etma_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    etma_sample_if.sink   samples,
    etma_mean_if.source   means
);
    import etma_pkg::*;

    localparam longint unsigned TOTAL_MAX =
        longint'(WINDOW) * ((longint'(1) << SAMPLE_BITS) - longint'(1));
    localparam int TW = $clog2(TOTAL_MAX + 1);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int NB = TW + FRAC_BITS + 1;
    localparam int RW = NB + 1;
    localparam logic [RW-1:0] NUM_ONE = {1'b1, {NB{1'b0}}};

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_TAIL,
        MODE_SHORT
    } mode_t;

    // front state
    mode_t                  mode_reg, mode_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [CW-1:0]          seen_reg, seen_next;
    logic [CW-1:0]          len_reg, len_next;
    logic [SAMPLE_BITS-1:0] hist_reg [WINDOW];
    logic                   hist_push, hist_drop2;

    // request stage
    logic          req_valid_reg, req_valid_next;
    logic [TW-1:0] req_total_reg;
    logic [CW-1:0] req_count_reg;
    logic          req_end_reg, req_short_reg;
    logic          req_adv;

    logic          issue_valid;
    logic [TW-1:0] issue_total;
    logic [CW-1:0] issue_count;
    logic          issue_end, issue_short;

    // multiply stage
    logic          mul_valid_reg;
    logic [NB-1:0] mul_num_reg, mul_q_reg;
    logic [CW-1:0] mul_count_reg;
    logic          mul_end_reg, mul_short_reg;
    logic          mul_adv;

    // output stage
    logic                 out_valid_reg;
    logic [MEAN_BITS-1:0] out_mean_reg;
    logic                 out_end_reg, out_short_reg;
    logic                 out_adv;

    logic          full;
    logic          accept;
    logic [TW-1:0] total_in, tail_total;
    logic [CW-1:0] seen_inc;

    logic [RW-1:0]      recip_tab [WINDOW+1];
    logic [NB-1:0]      num;
    logic [RW-1:0]      recip;
    logic [NB+RW-1:0]   prod;
    logic [NB-1:0]      qc, rem, q_fix;
    logic [MEAN_BITS-1:0] mean_sat;

    assign out_adv = !out_valid_reg || means.ready;
    assign mul_adv = !mul_valid_reg || out_adv;
    assign req_adv = !req_valid_reg || mul_adv;

    assign samples.ready = (mode_reg == MODE_NORMAL) && req_adv;
    assign accept        = samples.valid && samples.ready;

    assign full       = (seen_reg == CW'(WINDOW));
    assign seen_inc   = seen_reg + CW'(1);
    assign total_in   = full ? total_reg - TW'(hist_reg[WINDOW-1]) + TW'(samples.sample)
                             : total_reg + TW'(samples.sample);
    assign tail_total = total_reg - TW'(hist_reg[WINDOW-1]) - TW'(hist_reg[WINDOW-2]);

    always_comb
    begin
        mode_next   = mode_reg;
        total_next  = total_reg;
        seen_next   = seen_reg;
        len_next    = len_reg;
        hist_push   = 1'b0;
        hist_drop2  = 1'b0;
        issue_valid = 1'b0;
        issue_total = total_in;
        issue_count = full ? CW'(WINDOW) : seen_inc;
        issue_end   = 1'b0;
        issue_short = 1'b0;
        unique case (mode_reg)
            MODE_NORMAL:
            begin
                if (accept)
                begin
                    total_next  = total_in;
                    seen_next   = full ? seen_reg : seen_inc;
                    hist_push   = 1'b1;
                    issue_valid = full || !seen_reg[0];
                    if (samples.last_sample)
                    begin
                        len_next = CW'(WINDOW - 2);
                        if (!full && (seen_inc != CW'(WINDOW)))
                        begin
                            mode_next = MODE_SHORT;
                        end
                        else
                        begin
                            mode_next = MODE_TAIL;
                        end
                    end
                end
            end
            MODE_SHORT:
            begin
                issue_total = '0;
                issue_count = CW'(1);
                issue_end   = 1'b1;
                issue_short = 1'b1;
                if (req_adv)
                begin
                    issue_valid = 1'b1;
                    total_next  = '0;
                    seen_next   = '0;
                    mode_next   = MODE_NORMAL;
                end
            end
            MODE_TAIL:
            begin
                issue_total = tail_total;
                issue_count = len_reg;
                issue_end   = (len_reg < CW'(3));
                if (req_adv)
                begin
                    issue_valid = 1'b1;
                    hist_drop2  = 1'b1;
                    if (issue_end)
                    begin
                        total_next = '0;
                        seen_next  = '0;
                        mode_next  = MODE_NORMAL;
                    end
                    else
                    begin
                        total_next = tail_total;
                        len_next   = len_reg - CW'(2);
                    end
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase
        req_valid_next = req_adv ? issue_valid : req_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            total_reg     <= '0;
            seen_reg      <= '0;
            len_reg       <= '0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            len_reg       <= len_next;
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_push)
        begin
            hist_reg[0] <= samples.sample;
            for (int i = 1; i < WINDOW; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
        else if (hist_drop2)
        begin
            for (int i = 2; i < WINDOW; i++)
            begin
                hist_reg[i] <= hist_reg[i-2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_adv && issue_valid)
        begin
            req_total_reg <= issue_total;
            req_count_reg <= issue_count;
            req_end_reg   <= issue_end;
            req_short_reg <= issue_short;
        end
    end

    for (genvar g = 0; g <= WINDOW; g++)
    begin : g_recip
        if (g == 0)
        begin : g_zero
            assign recip_tab[g] = '0;
        end
        else
        begin : g_entry
            localparam logic [RW-1:0] RECIP = NUM_ONE / RW'(g);
            assign recip_tab[g] = RECIP;
        end
    end

    assign num   = (NB'(req_total_reg) << FRAC_BITS) + NB'(req_count_reg >> 1);
    assign recip = recip_tab[req_count_reg];
    assign prod  = (NB+RW)'(num) * (NB+RW)'(recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_adv)
            begin
                mul_valid_reg <= req_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_adv && req_valid_reg)
        begin
            mul_num_reg   <= num;
            mul_q_reg     <= prod[2*NB-1:NB];
            mul_count_reg <= req_count_reg;
            mul_end_reg   <= req_end_reg;
            mul_short_reg <= req_short_reg;
        end
    end

    assign qc    = NB'(mul_q_reg * NB'(mul_count_reg));
    assign rem   = mul_num_reg - qc;
    assign q_fix = mul_q_reg + NB'(rem >= NB'(mul_count_reg));

    if (NB > MEAN_BITS)
    begin : g_sat
        assign mean_sat = (|q_fix[NB-1:MEAN_BITS]) ? MEAN_MAX : q_fix[MEAN_BITS-1:0];
    end
    else
    begin : g_nosat
        assign mean_sat = MEAN_BITS'(q_fix);
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && mul_valid_reg)
        begin
            out_mean_reg  <= mean_sat;
            out_end_reg   <= mul_end_reg;
            out_short_reg <= mul_short_reg;
        end
    end

    assign means.valid      = out_valid_reg;
    assign means.mean_value = out_mean_reg;
    assign means.run_end    = out_end_reg;
    assign means.too_short  = out_short_reg;

    `ETMA_ASSERT_IMPL(a_seen_bound, 1'b1, seen_reg <= CW'(WINDOW), "seen count past window")
    `ETMA_ASSERT_IMPL(a_tail_len, mode_reg == MODE_TAIL, len_reg >= CW'(1), "empty tail length")
    `ETMA_ASSERT_IMPL(a_short_end, means.valid && means.too_short, means.run_end,
                      "short result not marked as run end")
    `ETMA_ASSERT_NEXT(a_short_clear, mode_reg == MODE_SHORT && req_adv,
                      mode_reg == MODE_NORMAL && seen_reg == '0, "series not restarted")
    `ETMA_ASSERT_IMPL(a_req_count, req_valid_reg, req_count_reg != '0, "zero divisor issued")

endmodule

// ===== verif/edge_tapered_moving_average_unit_tb.sv =====
// Self-checking testbench for the edge tapered moving average unit
module edge_tapered_moving_average_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import etma_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int SBITS        = SAMPLE_BITS_DEF;
    localparam int FBITS        = FRAC_BITS_DEF;
    localparam int TOTAL_BITS   = SBITS + $clog2(WIN);
    localparam int RANDOM_ITEMS = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;

    typedef logic [SBITS-1:0]      sample_t;
    typedef logic [TOTAL_BITS-1:0] total_t;
    typedef logic [MEAN_BITS-1:0]  mean_t;

    typedef struct packed {
        mean_t mean_value;
        logic  run_end;
        logic  too_short;
    } mean_rec_t;

    class mean_ledger;
        sample_t   history [WIN];
        total_t    window_total;
        int        seen_count;
        mean_rec_t pending_means [$];
        int        failures;

        function new();
            failures = 0;
            clear_series();
        endfunction

        function void clear_series();
            foreach (history[i])
                history[i] = '0;
            window_total = '0;
            seen_count   = 0;
        endfunction

        function mean_t scaled_mean(total_t total, int count);
            logic [63:0] q;
            q = ((64'(total) << FBITS) + 64'(count / 2)) / 64'(count);
            if (q > 64'(MEAN_MAX))
                return MEAN_MAX;
            return q[MEAN_BITS-1:0];
        endfunction

        function void add_mean(mean_t m, logic end_flag, logic short_flag);
            mean_rec_t r;
            r.mean_value = m;
            r.run_end    = end_flag;
            r.too_short  = short_flag;
            pending_means.push_back(r);
        endfunction

        function void note_sample(sample_t s, logic last_flag);
            int     k;
            int     len;
            int     drop;
            total_t tail;
            if (seen_count < WIN) begin
                window_total = window_total + total_t'(s);
                seen_count++;
                k = seen_count;
            end
            else begin
                window_total = window_total - total_t'(history[WIN-1]) + total_t'(s);
                k = WIN + 1;
            end
            for (int j = WIN - 1; j > 0; j--)
                history[j] = history[j-1];
            history[0] = s;

            if (k <= WIN) begin
                if (k % 2 == 1)
                    add_mean(scaled_mean(window_total, k), 1'b0, 1'b0);
            end
            else begin
                add_mean(scaled_mean(window_total, WIN), 1'b0, 1'b0);
            end

            if (last_flag) begin
                if (seen_count < WIN) begin
                    add_mean('0, 1'b1, 1'b1);
                end
                else begin
                    tail = window_total;
                    len  = WIN - 2;
                    drop = WIN - 1;
                    while (len >= 1) begin
                        tail = tail - total_t'(history[drop]) - total_t'(history[drop-1]);
                        drop -= 2;
                        add_mean(scaled_mean(tail, len), len < 3, 1'b0);
                        len -= 2;
                    end
                end
                clear_series();
            end
        endfunction

        function void check_mean(mean_t m, logic end_flag, logic short_flag);
            mean_rec_t want;
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected result mean_value %0d run_end %0b too_short %0b",
                         $time, m, end_flag, short_flag);
                failures++;
                return;
            end
            want = pending_means.pop_front();
            if (m !== want.mean_value) begin
                $display("%0t: mean_value expected %0d, actual %0d", $time, want.mean_value, m);
                failures++;
            end
            if (end_flag !== want.run_end) begin
                $display("%0t: run_end expected %0b, actual %0b", $time, want.run_end, end_flag);
                failures++;
            end
            if (short_flag !== want.too_short) begin
                $display("%0t: too_short expected %0b, actual %0b",
                         $time, want.too_short, short_flag);
                failures++;
            end
        endfunction

        function int pending();
            return pending_means.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   cycles;

    mean_ledger ledger = new();

    etma_sample_if #(.SAMPLE_BITS(SBITS)) samples_ch ();
    etma_mean_if                          means_ch ();

    edge_tapered_moving_average_unit #(
        .WINDOW      (WIN),
        .SAMPLE_BITS (SBITS),
        .FRAC_BITS   (FBITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .means   (means_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && means_ch.valid === 1'b1 && means_ch.ready === 1'b1)
            ledger.check_mean(means_ch.mean_value, means_ch.run_end, means_ch.too_short);
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 2) != 0)
            return 0;
        return pick_gap();
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return sample_t'($urandom_range(0, 15));
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_sample(sample_t s, logic last_flag, int gap);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid       <= 1'b1;
        samples_ch.sample      <= s;
        samples_ch.last_sample <= last_flag;
        do
            @(posedge clk);
        while (samples_ch.ready !== 1'b1);
        ledger.note_sample(s, last_flag);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        means_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                means_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                means_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int items;
        int len;
        cycles = 0;
        calm   = 1'b0;
        rst_n  = 1'b0;
        samples_ch.valid       <= 1'b0;
        samples_ch.sample      <= '0;
        samples_ch.last_sample <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample('1, 1'b1, sender_gap());
        send_sample('0, 1'b0, sender_gap());
        send_sample('1, 1'b1, sender_gap());
        for (int i = 0; i < WIN; i++)
            send_sample('1, i == WIN - 1, sender_gap());

        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, WIN - 1);
            else
                len = $urandom_range(WIN, 2 * WIN + 5);
            for (int i = 0; i < len; i++)
                send_sample(pick_sample(), i == len - 1, sender_gap());
            items += len;
        end
        samples_ch.valid <= 1'b0;
        calm = 1'b0;

        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
